// ----- hdl/mbeq_pkg.sv -----
// ----------------------------------------------------------------------------
// mbeq_pkg: shared types and constants of the multiband equalizer
// Holds the controller states, command and register codes, coefficient slot
// numbers, the history word layout and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package mbeq_pkg;

    localparam int DEF_MAX_BANDS    = 32;
    localparam int DEF_NUM_CHANNELS = 2;

    // Command codes of an input request.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_GAIN   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BAND_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SECOND_PASS = 2'd1;
    localparam logic [1:0] CFG_PREAMP_L    = 2'd2;
    localparam logic [1:0] CFG_PREAMP_R    = 2'd3;

    // Slots of one band in the parameter memory.
    localparam int SLOT_ALPHA = 0;
    localparam int SLOT_BETA  = 1;
    localparam int SLOT_GAMMA = 2;
    localparam int SLOT_GAIN0 = 3;

    localparam logic [5:0]  RST_BAND_COUNT = 6'd10;
    localparam logic [30:0] RST_PREAMP     = 31'h1000_0000;

    localparam int ACC_W = 40;
    localparam int SUM_W = 48;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRE,
        ST_BAND,
        ST_FINAL
    } t_state;

    // History of one section for one channel and one pass.
    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] y1;
        logic [31:0] y2;
    } t_hist;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/multiband_iir_equalizer.sv -----
// ----------------------------------------------------------------------------
// multiband_iir_equalizer: graphic equalizer built from parallel bandpass IIRs
// One shared multiplier walks the bands of one sample at a time, with the
// coefficients, gains and filter histories held in two block memories.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps both memories to zero; input requests
// are held off during that sweep, configuration writes are taken at once.
// A coefficient or gain write request is written to the parameter memory as
// it is accepted. A sample request runs through the preamp steps, then the
// band steps for each active band in one or two passes, then the final step,
// where its result is loaded into the output register once the previous
// result has been taken; each band uses the single multiplier and memory
// read port for four products and the history read-modify-write. The next
// request is accepted as soon as the result is registered, even while the
// result is still waiting on the output side.
// ----------------------------------------------------------------------------
module multiband_iir_equalizer #(
    parameter int MAX_BANDS    = mbeq_pkg::DEF_MAX_BANDS,
    parameter int NUM_CHANNELS = mbeq_pkg::DEF_NUM_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic        i_channel,
    input  logic [4:0]  i_band,
    input  logic [1:0]  i_coef_select,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [15:0] i_sample_in,
    input  logic signed [1:0]  i_dither,
    // Results.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_sample_out,
    output logic        o_clipped,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int BAND_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int BCNT_W  = $clog2(MAX_BANDS + 1);
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W  = $clog2(3 + NUM_CHANNELS);
    localparam int PAR_AW  = BAND_W + SLOT_W;
    localparam int HIST_AW = 1 + BAND_W + CH_W;
    localparam int CLR_W   = (PAR_AW > HIST_AW) ? PAR_AW : HIST_AW;
    localparam int HIST_W  = $bits(mbeq_pkg::t_hist);
    localparam int TOT_W   = mbeq_pkg::SUM_W + 3;
    localparam logic CH1_OK = (NUM_CHANNELS > 1);

    // Control state.
    mbeq_pkg::t_state r_state, n_state;
    logic [3:0]        r_step;
    logic [CLR_W-1:0]  r_clr;
    logic [BCNT_W-1:0] r_band;
    logic [BCNT_W-1:0] r_nb;
    logic              r_pass;
    logic              r_out_valid;

    // Configuration registers.
    logic [5:0]  r_band_count;
    logic        r_second;
    logic [30:0] r_pre_l;
    logic [30:0] r_pre_r;

    // Sample datapath registers.
    logic [CH_W-1:0]                    r_ch;
    logic signed [15:0]                 r_sample;
    logic signed [1:0]                  r_dith;
    logic signed [31:0]                 r_pcm;
    logic [31:0]                        r_x;
    mbeq_pkg::t_hist                    r_hist;
    logic [31:0]                        r_gain;
    logic signed [mbeq_pkg::ACC_W-1:0]  r_acc;
    logic signed [mbeq_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic signed [15:0]                 r_sample_out;
    logic                               r_clipped;

    // Memory and multiplier wiring.
    logic              par_we;
    logic [PAR_AW-1:0] par_waddr, par_raddr;
    logic [31:0]       par_wdata, par_rdata;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr, hist_addr;
    mbeq_pkg::t_hist    hist_wdata, hist_rdata;
    logic               mac_ld;
    logic signed [32:0] mac_a;
    logic signed [31:0] mac_b;
    logic signed [64:0] mac_prod;

    // Request decode.
    logic in_acc, ch_ok, band_ok, out_free, last_band, go_second;
    logic [BAND_W-1:0] band_idx;
    logic [31:0]       y_sat;
    logic signed [31:0] pcm_next;
    logic signed [TOT_W-1:0] total, rounded;
    logic signed [15:0] res_val;
    logic               res_clip;

    assign in_acc    = i_in_valid && o_in_ready;
    assign ch_ok     = (i_channel == 1'b0) || CH1_OK;
    assign band_ok   = ({2'b00, i_band} < 7'(MAX_BANDS));
    assign out_free  = !r_out_valid || i_out_ready;
    assign band_idx  = r_band[BAND_W-1:0];
    assign last_band = (r_band == r_nb - BCNT_W'(1));
    assign go_second = !r_pass && r_second;
    assign hist_addr = {r_pass, band_idx, r_ch};

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

    mbeq_ram #(.WIDTH(32), .DEPTH(1 << PAR_AW)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    mbeq_ram #(.WIDTH(HIST_W), .DEPTH(1 << HIST_AW)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    mbeq_mac u_mac (
        .i_clk  (i_clk),
        .i_ld   (mac_ld),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_prod)
    );

    // The section output is the saturated sum of its three terms.
    assign y_sat = mbeq_pkg::sat32(64'(r_acc));

    // Each weighted band output adds into the running sum on the last step.
    assign n_sum = r_sum + mbeq_pkg::SUM_W'(mac_prod >>> 28);

    // Scaled sample plus dither, from the preamp product.
    assign pcm_next = 32'(mac_prod >>> 16) + (32'(r_dith) <<< 12);

    // Output stage: 4*sum + pcm - dither*2^12 in Q14, rounded half up.
    assign total   = (TOT_W'(r_sum) <<< 2) + TOT_W'(r_pcm) - (TOT_W'(r_dith) <<< 12);
    assign rounded = (total + TOT_W'(8192)) >>> 14;
    always_comb begin
        res_clip = 1'b0;
        res_val  = rounded[15:0];
        if (rounded > TOT_W'(32767)) begin
            res_val  = 16'sh7FFF;
            res_clip = 1'b1;
        end else if (rounded < -TOT_W'(32768)) begin
            res_val  = 16'sh8000;
            res_clip = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbeq_pkg::ST_CLEAR: begin
                if (&r_clr) begin
                    n_state = mbeq_pkg::ST_IDLE;
                end
            end
            mbeq_pkg::ST_IDLE: begin
                if (in_acc && i_command == mbeq_pkg::CMD_SAMPLE && ch_ok) begin
                    n_state = mbeq_pkg::ST_PRE;
                end
            end
            mbeq_pkg::ST_PRE: begin
                if (r_step == 4'd2) begin
                    n_state = (r_nb == '0) ? mbeq_pkg::ST_FINAL : mbeq_pkg::ST_BAND;
                end
            end
            mbeq_pkg::ST_BAND: begin
                if (r_step == 4'd8 && last_band && !go_second) begin
                    n_state = mbeq_pkg::ST_FINAL;
                end
            end
            mbeq_pkg::ST_FINAL: begin
                if (out_free) begin
                    n_state = mbeq_pkg::ST_IDLE;
                end
            end
            default: n_state = mbeq_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the state machine: memory ports and multiplier loads.
    always_comb begin
        o_in_ready = 1'b0;
        par_we     = 1'b0;
        par_waddr  = r_clr[PAR_AW-1:0];
        par_wdata  = '0;
        par_raddr  = {band_idx, SLOT_W'(mbeq_pkg::SLOT_ALPHA)};
        hist_we    = 1'b0;
        hist_waddr = hist_addr;
        hist_wdata = '0;
        hist_raddr = hist_addr;
        mac_ld     = 1'b0;
        mac_a      = '0;
        mac_b      = '0;
        case (r_state)
            mbeq_pkg::ST_CLEAR: begin
                par_we     = 1'b1;
                hist_we    = 1'b1;
                hist_waddr = r_clr[HIST_AW-1:0];
            end
            mbeq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                par_wdata  = i_coef_value;
                if (i_command == mbeq_pkg::CMD_COEF) begin
                    par_waddr = {BAND_W'(i_band), SLOT_W'(i_coef_select)};
                    par_we    = in_acc && ch_ok && band_ok && (i_coef_select != 2'd3);
                end else begin
                    par_waddr = {BAND_W'(i_band),
                                 SLOT_W'(mbeq_pkg::SLOT_GAIN0) + SLOT_W'(i_channel)};
                    par_we    = in_acc && ch_ok && band_ok &&
                                (i_command == mbeq_pkg::CMD_GAIN);
                end
            end
            mbeq_pkg::ST_PRE: begin
                mac_ld = (r_step == 4'd0);
                mac_a  = 33'(r_sample);
                mac_b  = (r_ch == '0) ? {1'b0, r_pre_l} : {1'b0, r_pre_r};
            end
            mbeq_pkg::ST_BAND: begin
                case (r_step)
                    4'd0: begin
                        par_raddr = {band_idx, SLOT_W'(mbeq_pkg::SLOT_ALPHA)};
                    end
                    4'd1: begin
                        par_raddr = {band_idx, SLOT_W'(mbeq_pkg::SLOT_BETA)};
                        mac_ld    = 1'b1;
                        mac_a     = 33'($signed(r_x)) - 33'($signed(hist_rdata.x2));
                        mac_b     = par_rdata;
                    end
                    4'd2: begin
                        par_raddr = {band_idx, SLOT_W'(mbeq_pkg::SLOT_GAMMA)};
                        mac_ld    = 1'b1;
                        mac_a     = 33'($signed(r_hist.y2));
                        mac_b     = par_rdata;
                    end
                    4'd3: begin
                        par_raddr = {band_idx, SLOT_W'(mbeq_pkg::SLOT_GAIN0) + SLOT_W'(r_ch)};
                        mac_ld    = 1'b1;
                        mac_a     = 33'($signed(r_hist.y1));
                        mac_b     = par_rdata;
                    end
                    4'd6: begin
                        mac_ld     = 1'b1;
                        mac_a      = 33'($signed(y_sat));
                        mac_b      = r_gain;
                        hist_we    = 1'b1;
                        hist_wdata = '{x1: r_x, x2: r_hist.x1, y1: y_sat, y2: r_hist.y1};
                    end
                    default: begin
                        mac_ld = 1'b0;
                    end
                endcase
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mbeq_pkg::ST_CLEAR;
            r_step       <= '0;
            r_clr        <= '0;
            r_band       <= '0;
            r_pass       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_band_count <= mbeq_pkg::RST_BAND_COUNT;
            r_second     <= 1'b0;
            r_pre_l      <= mbeq_pkg::RST_PREAMP;
            r_pre_r      <= mbeq_pkg::RST_PREAMP;
        end else begin
            r_state <= n_state;
            if (r_state == mbeq_pkg::ST_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mbeq_pkg::CFG_BAND_COUNT:  r_band_count <= i_cfg_data[5:0];
                    mbeq_pkg::CFG_SECOND_PASS: r_second     <= i_cfg_data[0];
                    mbeq_pkg::CFG_PREAMP_L:    r_pre_l      <= i_cfg_data[30:0];
                    mbeq_pkg::CFG_PREAMP_R:    r_pre_r      <= i_cfg_data[30:0];
                    default:                   r_second     <= r_second;
                endcase
            end

            // Step counter runs through the preamp and per-band sequences.
            if (r_state == mbeq_pkg::ST_PRE) begin
                r_step <= (r_step == 4'd2) ? 4'd0 : r_step + 4'd1;
                r_band <= '0;
                r_pass <= 1'b0;
            end else if (r_state == mbeq_pkg::ST_BAND) begin
                if (r_step == 4'd8) begin
                    r_step <= 4'd0;
                    if (last_band) begin
                        r_band <= '0;
                        r_pass <= 1'b1;
                    end else begin
                        r_band <= r_band + BCNT_W'(1);
                    end
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end else begin
                r_step <= '0;
            end

            if (r_state == mbeq_pkg::ST_FINAL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == mbeq_pkg::ST_IDLE && in_acc) begin
            r_ch     <= CH_W'(i_channel);
            r_sample <= i_sample_in;
            r_dith   <= i_dither;
            if (int'(r_band_count) > MAX_BANDS) begin
                r_nb <= BCNT_W'(MAX_BANDS);
            end else begin
                r_nb <= BCNT_W'(r_band_count);
            end
        end

        if (r_state == mbeq_pkg::ST_PRE && r_step == 4'd2) begin
            r_pcm <= pcm_next;
            r_x   <= pcm_next;
            r_sum <= '0;
        end

        if (r_state == mbeq_pkg::ST_BAND) begin
            case (r_step)
                4'd1: r_hist <= hist_rdata;
                4'd3: r_acc  <= mbeq_pkg::ACC_W'(mac_prod >>> 30);
                4'd4: begin
                    r_gain <= par_rdata;
                    r_acc  <= r_acc - mbeq_pkg::ACC_W'(mac_prod >>> 30);
                end
                4'd5: r_acc  <= r_acc + mbeq_pkg::ACC_W'(mac_prod >>> 30);
                4'd8: begin
                    r_sum <= n_sum;
                    // The second pass sees the saturated first-pass sum.
                    if (last_band && go_second) begin
                        r_x <= mbeq_pkg::sat32(64'(n_sum));
                    end
                end
                default: r_gain <= r_gain;
            endcase
        end

        if (r_state == mbeq_pkg::ST_FINAL && out_free) begin
            r_sample_out <= res_val;
            r_clipped    <= res_clip;
        end
    end

endmodule

// ----- hdl/mbeq_ram.sv -----
// ----------------------------------------------------------------------------
// mbeq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mbeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mbeq_mac.sv -----
// ----------------------------------------------------------------------------
// mbeq_mac: shared multiplier
// Operands are registered on a load, and the 65-bit product is registered
// from the operand registers.
// ----------------------------------------------------------------------------
module mbeq_mac (
    input  logic               i_clk,
    input  logic               i_ld,
    input  logic signed [32:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [64:0] o_prod
);

    logic signed [32:0] r_a;
    logic signed [31:0] r_b;
    logic signed [64:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_prod <= 65'(r_a) * 65'(r_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- tb/multiband_iir_equalizer_tb.sv -----
// ----------------------------------------------------------------------------
// multiband_iir_equalizer_tb: self-checking bench of the multiband equalizer
// Drives sample, coefficient and gain requests through the input handshake
// and register writes through the configuration channel. Sample results are
// compared with a bit-exact fixed-point model of the parallel bandpass sections
// kept in this bench, or with a typed row's own value. A directed table runs
// first, then random phases under several band counts, pass modes and preamps.
// ----------------------------------------------------------------------------
module multiband_iir_equalizer_tb;

    // Codes the package does not name: an unused command and the coefficient
    // select codes, the unused slot among them.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] SEL_ALPHA  = 2'd0;
    localparam logic [1:0] SEL_BETA   = 2'd1;
    localparam logic [1:0] SEL_GAMMA  = 2'd2;
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    localparam int NBANDS    = 32;
    localparam int NCH       = 2;
    // Cycles without any handshake before the run is declared hung. The
    // limit lies well above the slowest sample (32 bands, two passes), the
    // clearing sweep after reset and the longest stall.
    localparam int IDLE_LIMIT = 8000;
    localparam int DRAIN_WAIT = 700;

    typedef struct {
        logic [1:0]  cmd;
        logic        ch;
        logic [4:0]  band;
        logic [1:0]  sel;
        logic [31:0] val;
        logic [15:0] smp;
        logic [1:0]  dth;
        bit          typed;   // expected result written in the table
        logic [15:0] t_smp;
        logic        t_clip;
    } t_eq_req;

    typedef struct {
        logic [15:0] smp;
        logic        clip;
    } t_eq_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic        i_channel;
    logic [4:0]  i_band;
    logic [1:0]  i_coef_select;
    logic signed [31:0] i_coef_value;
    logic signed [15:0] i_sample_in;
    logic signed [1:0]  i_dither;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [15:0] o_sample_out;
    logic        o_clipped;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    multiband_iir_equalizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_band        (i_band),
        .i_coef_select (i_coef_select),
        .i_coef_value  (i_coef_value),
        .i_sample_in   (i_sample_in),
        .i_dither      (i_dither),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample_out  (o_sample_out),
        .o_clipped     (o_clipped),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Equalizer model: configuration, tables and the section histories.
    // Histories are indexed [pass][band][channel][tap].
    // ------------------------------------------------------------------
    logic [5:0]  eq_bands;
    logic        eq_two_pass;
    logic [30:0] eq_pre_l;
    logic [30:0] eq_pre_r;
    int          coef_tab [NBANDS][3];
    int          gain_tab [NBANDS][NCH];
    int          x_hist [2][NBANDS][NCH][2];
    int          y_hist [2][NBANDS][NCH][2];

    t_eq_res     pending_results[$];
    int          errors      = 0;
    int          n_samples   = 0;
    int          n_results   = 0;
    int          n_clipped   = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    bit          sender_gaps = 1'b0;
    bit          rx_stalls   = 1'b0;
    logic [15:0] rx_pattern  = 16'hFFFF;

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    // One bandpass section: y = alpha*(x - x2) + gamma*y1 - beta*y2, each
    // product floored to Q12, then the history shifts by one.
    function automatic int bandpass(int p, int b, int c, int x);
        longint diff;
        longint acc;
        int     y;
        diff = longint'(x) - longint'(x_hist[p][b][c][1]);
        acc  = ((longint'(coef_tab[b][0]) * diff) >>> 30)
             + ((longint'(coef_tab[b][2]) * longint'(y_hist[p][b][c][0])) >>> 30)
             - ((longint'(coef_tab[b][1]) * longint'(y_hist[p][b][c][1])) >>> 30);
        y = clamp32(acc);
        x_hist[p][b][c][1] = x_hist[p][b][c][0];
        x_hist[p][b][c][0] = x;
        y_hist[p][b][c][1] = y_hist[p][b][c][0];
        y_hist[p][b][c][0] = y;
        return y;
    endfunction

    // Applies one accepted request to the model. Returns 1 with the result
    // when the request is a sample.
    function automatic bit equalize(t_eq_req r, output t_eq_res res);
        int     nb;
        int     c;
        int     x2;
        int     y;
        longint pre;
        longint pcm;
        longint dq;
        longint acc_sum;
        longint total;
        longint rounded;
        res.smp  = '0;
        res.clip = 1'b0;
        c = int'(r.ch);
        if (r.cmd == mbeq_pkg::CMD_COEF) begin
            if (r.sel != SEL_UNUSED) coef_tab[r.band][r.sel] = r.val;
            return 1'b0;
        end
        if (r.cmd == mbeq_pkg::CMD_GAIN) begin
            gain_tab[r.band][c] = r.val;
            return 1'b0;
        end
        if (r.cmd != mbeq_pkg::CMD_SAMPLE) return 1'b0;

        nb  = (int'(eq_bands) > NBANDS) ? NBANDS : int'(eq_bands);
        pre = (c == 0) ? longint'(eq_pre_l) : longint'(eq_pre_r);
        dq  = longint'($signed(r.dth)) * 4096;
        pcm = ((longint'($signed(r.smp)) * pre) >>> 16) + dq;
        acc_sum = 0;
        for (int b = 0; b < nb; b++) begin
            y = bandpass(0, b, c, int'(pcm));
            acc_sum += (longint'(y) * longint'(gain_tab[b][c])) >>> 28;
        end
        if (eq_two_pass) begin
            x2 = clamp32(acc_sum);
            for (int b = 0; b < nb; b++) begin
                y = bandpass(1, b, c, x2);
                acc_sum += (longint'(y) * longint'(gain_tab[b][c])) >>> 28;
            end
        end
        total   = acc_sum * 4 + pcm - dq;
        rounded = (total + 8192) >>> 14;
        if (rounded > 32767) begin
            rounded  = 32767;
            res.clip = 1'b1;
        end else if (rounded < -32768) begin
            rounded  = -32768;
            res.clip = 1'b1;
        end
        res.smp = rounded[15:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks. Inputs move at the falling edge; acceptance is seen
    // at the rising edge, where the model is advanced.
    // ------------------------------------------------------------------
    task automatic send_request(t_eq_req r);
        t_eq_res res;
        if (sender_gaps && burst_left == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end else begin
            @(negedge i_clk);
        end
        i_command     = r.cmd;
        i_channel     = r.ch;
        i_band        = r.band;
        i_coef_select = r.sel;
        i_coef_value  = r.val;
        i_sample_in   = r.smp;
        i_dither      = r.dth;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0) burst_left--;
        if (equalize(r, res)) begin
            n_samples++;
            // A typed row is checked against its written value instead.
            if (r.typed) begin
                res.smp  = r.t_smp;
                res.clip = r.t_clip;
            end
            pending_results.push_back(res);
        end
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mbeq_pkg::CFG_BAND_COUNT:  eq_bands    = data[5:0];
            mbeq_pkg::CFG_SECOND_PASS: eq_two_pass = data[0];
            mbeq_pkg::CFG_PREAMP_L:    eq_pre_l    = data[30:0];
            default:                   eq_pre_r    = data[30:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits until every expected result is back and the input is quiet, so
    // that the block sits idle before a register write.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating stall pattern that each phase
    // reloads; in some phases it never stalls.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_pattern  <= {rx_pattern[0], rx_pattern[15:1]};
        i_out_ready <= rx_stalls ? rx_pattern[0] : 1'b1;
    end

    // Result checker and hang watchdog.
    always @(posedge i_clk) begin
        t_eq_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (o_clipped) n_clipped++;
            if (pending_results.size() == 0) begin
                $error("unexpected result sample_out=%0d clipped=%0b",
                       o_sample_out, o_clipped);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_sample_out !== want.smp) begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want.smp), o_sample_out);
                    errors++;
                end
                if (o_clipped !== want.clip) begin
                    $error("clipped: expected %0b, got %0b", want.clip, o_clipped);
                    errors++;
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table, run at the reset settings (ten bands, one pass, unity
    // preamps). While all gains are zero the result is a quarter of the
    // sample rounded to nearest, with the dither cancelled, so those rows
    // carry their expected value.
    // ------------------------------------------------------------------
    localparam int N_DIRECTED = 22;
    t_eq_req directed_rows [N_DIRECTED] = '{
        '{mbeq_pkg::CMD_SAMPLE, 1'b0, 5'd0, SEL_ALPHA, 32'h0, 16'h7FFF, 2'b00, 1, 16'd8192, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b1, 5'd0, SEL_ALPHA, 32'h0, 16'h8000, 2'b10, 1, 16'hE000, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b0, 5'd31, SEL_ALPHA, 32'h0, 16'h0000, 2'b01, 1, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b1, 5'd0, SEL_ALPHA, 32'h0, 16'h0001, 2'b11, 1, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b0, 5'd0, SEL_ALPHA, 32'h0, 16'h0002, 2'b00, 1, 16'd1, 1'b0},
        // Unused command: ignored, nothing comes back.
        '{CMD_UNUSED, 1'b1, 5'd31, SEL_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 2'b11, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_COEF, 1'b0, 5'd0, SEL_ALPHA, 32'h4000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_COEF, 1'b0, 5'd0, SEL_BETA, 32'h7FFF_FFFF, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_COEF, 1'b1, 5'd0, SEL_GAMMA, 32'h8000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        // Unused coefficient slot: the write is dropped.
        '{mbeq_pkg::CMD_COEF, 1'b0, 5'd1, SEL_UNUSED, 32'h7FFF_FFFF, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_COEF, 1'b0, 5'd9, SEL_ALPHA, 32'h2000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_COEF, 1'b0, 5'd31, SEL_ALPHA, 32'h4000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_GAIN, 1'b0, 5'd0, SEL_ALPHA, 32'h1000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_GAIN, 1'b1, 5'd0, SEL_ALPHA, 32'h7FFF_FFFF, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_GAIN, 1'b0, 5'd9, SEL_ALPHA, 32'h8000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_GAIN, 1'b1, 5'd31, SEL_ALPHA, 32'h1000_0000, 16'h0, 2'b00, 0, 16'd0, 1'b0},
        // Filtered samples from here on are checked against the model.
        '{mbeq_pkg::CMD_SAMPLE, 1'b0, 5'd0, SEL_ALPHA, 32'h0, 16'h7FFF, 2'b01, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b0, 5'd0, SEL_ALPHA, 32'h0, 16'h8000, 2'b10, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b1, 5'd0, SEL_ALPHA, 32'h0, 16'h7FFF, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b1, 5'd0, SEL_ALPHA, 32'h0, 16'h8000, 2'b11, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b0, 5'd0, SEL_ALPHA, 32'h0, 16'h0000, 2'b00, 0, 16'd0, 1'b0},
        '{mbeq_pkg::CMD_SAMPLE, 1'b1, 5'd0, SEL_ALPHA, 32'h0, 16'h1234, 2'b01, 0, 16'd0, 1'b0}
    };

    // Settings of the random phases: band count, second pass, preamps.
    // They cover zero bands, a count above the maximum, zero and full-scale
    // preamps, and both pass modes.
    localparam int N_PHASES = 6;
    logic [31:0] phase_cfg [N_PHASES][4] = '{
        '{32'd1,  32'd0, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'd32, 32'd1, 32'h0800_0000, 32'h1800_0000},
        '{32'd0,  32'd1, 32'h1000_0000, 32'h1000_0000},
        '{32'd63, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{32'd4,  32'd0, 32'h2000_0000, 32'h0400_0000},
        '{32'd10, 32'd1, 32'h1000_0000, 32'h1000_0000}
    };

    initial begin
        t_eq_req r;
        int      pick;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = mbeq_pkg::CMD_SAMPLE;
        i_channel     = 1'b0;
        i_band        = '0;
        i_coef_select = SEL_ALPHA;
        i_coef_value  = '0;
        i_sample_in   = '0;
        i_dither      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = mbeq_pkg::CFG_BAND_COUNT;
        i_cfg_data    = '0;
        i_out_ready   = 1'b1;

        eq_bands    = mbeq_pkg::RST_BAND_COUNT;
        eq_two_pass = 1'b0;
        eq_pre_l    = mbeq_pkg::RST_PREAMP;
        eq_pre_r    = mbeq_pkg::RST_PREAMP;
        foreach (coef_tab[b, k]) coef_tab[b][k] = 0;
        foreach (gain_tab[b, c]) gain_tab[b][c] = 0;
        foreach (x_hist[p, b, c, t]) begin
            x_hist[p][b][c][t] = 0;
            y_hist[p][b][c][t] = 0;
        end

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with gaps and stalls on.
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
        rx_pattern  = 16'hB6D5;
        for (int i = 0; i < N_DIRECTED; i++) send_request(directed_rows[i]);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            write_register(mbeq_pkg::CFG_BAND_COUNT,  phase_cfg[ph][0]);
            write_register(mbeq_pkg::CFG_SECOND_PASS, phase_cfg[ph][1]);
            write_register(mbeq_pkg::CFG_PREAMP_L,    phase_cfg[ph][2]);
            write_register(mbeq_pkg::CFG_PREAMP_R,    phase_cfg[ph][3]);
            // Every other phase runs back to back with no idling at all.
            sender_gaps = ph[0];
            rx_stalls   = ph[0];
            // At least one ready slot in every rotation keeps the receiver alive.
            rx_pattern  = 16'($urandom) | 16'h0101;

            // Each phase reloads some coefficients first, then mostly samples with
            // coefficient and gain writes and junk requests mixed in.
            for (int n = 0; n < 85; n++) begin
                pick    = $urandom_range(0, 99);
                r       = '{default: '0};
                r.ch    = 1'($urandom_range(0, 1));
                r.band  = 5'($urandom_range(0, 31));
                r.val   = $urandom;
                if ($urandom_range(0, 3) != 0) r.val = $signed(r.val) >>> $urandom_range(1, 6);
                r.smp   = 16'($urandom);
                r.dth   = 2'($urandom);
                r.sel   = 2'($urandom_range(0, 2));
                if (n < 12 || pick < 15) begin
                    r.cmd = mbeq_pkg::CMD_COEF;
                    if (pick < 3) r.sel = SEL_UNUSED;
                end else if (pick < 25) begin
                    r.cmd = mbeq_pkg::CMD_GAIN;
                end else if (pick < 29) begin
                    r.cmd = CMD_UNUSED;
                end else begin
                    r.cmd = mbeq_pkg::CMD_SAMPLE;
                end
                // Keep most of the writes on the bands that are actually in use, if there are any.
                if (r.cmd != mbeq_pkg::CMD_SAMPLE && phase_cfg[ph][0] != 0 && pick < 80)
                    r.band = 5'($urandom_range(0, (phase_cfg[ph][0] > 32)
                                               ? 31 : phase_cfg[ph][0] - 1));
                send_request(r);
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d samples over %0d setting phases; %0d results checked, %0d clipped.",
                 n_samples, N_PHASES + 1, n_results, n_clipped);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors,
                     pending_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- multiband_iir_equalizer.f -----
hdl/mbeq_pkg.sv
hdl/mbeq_ram.sv
hdl/mbeq_mac.sv
hdl/multiband_iir_equalizer.sv
tb/multiband_iir_equalizer_tb.sv
